### hdl/assert_macros.svh
// Assertion macros used by the section address translator top level.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/sat_pkg.sv
// Types and constants for the section address translator.
// No dependencies; used by every module under hdl except sat_ram.
package sat_pkg;

  localparam int ADDR_BITS = 32;
  localparam int CMD_W     = 2;
  localparam int ENTRY_W   = 4;
  localparam int CNT_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int GRP_LANES = 8;
  localparam int POS_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_V2F  = 2'd1,
    CMD_F2V  = 2'd2,
    CMD_BAD  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOAD     = 2'd0,
    ST_IDENT    = 2'd1,
    ST_MAPPED   = 2'd2,
    ST_UNMAPPED = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [ENTRY_W-1:0]   entry_index;
    logic [ADDR_BITS-1:0] vstart;
    logic [ADDR_BITS-1:0] rstart;
    logic [ADDR_BITS-1:0] addr;
  } sat_item_t;

  typedef struct packed {
    logic                 en;
    logic [ENTRY_W-1:0]   idx;
    logic [ADDR_BITS-1:0] vstart;
    logic [ADDR_BITS-1:0] rstart;
  } sat_wr_t;

endpackage

### hdl/section_address_translator.sv
// Section address translator top level: a table of section start pairs
// (virtual start, raw file start) loaded by load items, and translation of
// query items from virtual address to file offset or back. One item enters
// per clock cycle; each item gives one result, registered at the input and
// then passed through lane compares, a two-level priority encoder, a RAM read
// of the chosen section and a final add. A stall on the result side holds the
// whole pipeline. Depends on sat_pkg, sat_lanes, sat_prio, sat_ram.
module section_address_translator
  import sat_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CNT_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ENTRY_W-1:0]   in_entry_index,
  input  logic [ADDR_BITS-1:0] in_entry_virtual_start,
  input  logic [ADDR_BITS-1:0] in_entry_raw_start,
  input  logic [ADDR_BITS-1:0] in_query_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_BITS-1:0] out_translated_address,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ENTRY_W-1:0]   out_hit_section
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  logic                    adv;
  logic [CNT_W-1:0]        section_count_r;
  logic                    s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  sat_item_t               s1_item_r, s2_item_r, s3_item_r, s4_item_r, s5_item_r;
  logic                    s3_ident_r, s4_ident_r, s5_ident_r;
  logic [AW-1:0]           s5_hit_r;
  logic                    ident_s2;
  logic [AW-1:0]           hit_s4;
  logic [MAX_SECTIONS-1:0] ge_s2;
  sat_wr_t                 lane_wr;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ADDR_BITS-1:0]    vs_rd, rs_rd;
  logic [ADDR_BITS-1:0]    key_sel, other_sel;

  logic                    out_valid_r;
  logic [ADDR_BITS-1:0]    out_addr_r, out_addr_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [ENTRY_W-1:0]      out_hit_r, out_hit_nxt;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_count_r <= '0;
    end else if (cfg_wr_en) begin
      section_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r.cmd         <= cmd_t'(in_cmd);
      s1_item_r.entry_index <= in_entry_index;
      s1_item_r.vstart      <= in_entry_virtual_start;
      s1_item_r.rstart      <= in_entry_raw_start;
      s1_item_r.addr        <= in_query_address;
      s2_item_r             <= s1_item_r;
      s3_item_r             <= s2_item_r;
      s4_item_r             <= s3_item_r;
      s5_item_r             <= s4_item_r;
      s3_ident_r            <= ident_s2;
      s4_ident_r            <= s3_ident_r;
      s5_ident_r            <= s4_ident_r;
      s5_hit_r              <= hit_s4;
    end
  end

  assign lane_wr.en     = s1_valid_r && (s1_item_r.cmd == CMD_LOAD);
  assign lane_wr.idx    = s1_item_r.entry_index;
  assign lane_wr.vstart = s1_item_r.vstart;
  assign lane_wr.rstart = s1_item_r.rstart;

  sat_lanes #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_lanes (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .wr    (lane_wr),
    .v2f   (s1_item_r.cmd == CMD_V2F),
    .addr  (s1_item_r.addr),
    .count (section_count_r),
    .ge    (ge_s2),
    .ident (ident_s2)
  );

  sat_prio #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .AW          (AW)
  ) u_prio (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ge    (ge_s2),
    .hit   (hit_s4)
  );

  // the table copy for the final add is written where it is read, so that
  // later loads cannot overtake a query in flight
  assign ram_we    = adv && s4_valid_r && (s4_item_r.cmd == CMD_LOAD) &&
                     (32'(s4_item_r.entry_index) < MAX_SECTIONS);
  assign ram_waddr = AW'(s4_item_r.entry_index);

  sat_ram #(
    .WIDTH(ADDR_BITS),
    .DEPTH(MAX_SECTIONS),
    .AW   (AW)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s4_item_r.vstart),
    .re    (adv),
    .raddr (hit_s4),
    .rdata (vs_rd)
  );

  sat_ram #(
    .WIDTH(ADDR_BITS),
    .DEPTH(MAX_SECTIONS),
    .AW   (AW)
  ) u_rram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s4_item_r.rstart),
    .re    (adv),
    .raddr (hit_s4),
    .rdata (rs_rd)
  );

  assign key_sel   = (s5_item_r.cmd == CMD_V2F) ? vs_rd : rs_rd;
  assign other_sel = (s5_item_r.cmd == CMD_V2F) ? rs_rd : vs_rd;

  always_comb begin
    out_addr_nxt   = '0;
    out_status_nxt = ST_UNMAPPED;
    out_hit_nxt    = '0;
    unique case (s5_item_r.cmd)
      CMD_LOAD: begin
        out_status_nxt = ST_LOAD;
      end
      CMD_V2F, CMD_F2V: begin
        if (s5_ident_r) begin
          out_addr_nxt   = s5_item_r.addr;
          out_status_nxt = ST_IDENT;
        end else begin
          out_addr_nxt   = other_sel + (s5_item_r.addr - key_sel);
          out_status_nxt = ST_MAPPED;
          out_hit_nxt    = ENTRY_W'(s5_hit_r);
        end
      end
      default: begin
        out_status_nxt = ST_UNMAPPED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
      out_hit_r    <= out_hit_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_translated_address = out_addr_r;
  assign out_status             = out_status_r;
  assign out_hit_section        = out_hit_r;

  `SAT_ASSERT_NEXT(a_pipe_moves, !in_stall, out_valid_r == $past(s5_valid_r))
  `SAT_ASSERT_NOW(a_load_zero, out_valid_r && (out_status_r == ST_LOAD),
                  (out_addr_r == '0) && (out_hit_r == '0))
  `SAT_ASSERT_NOW(a_unmapped_zero, out_valid_r && (out_status_r == ST_UNMAPPED),
                  (out_addr_r == '0) && (out_hit_r == '0))

endmodule

### hdl/sat_ram.sv
// Generic single write port RAM with registered read.
// Depends on nothing.
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/sat_lanes.sv
// Section start lanes: one register pair per section, each with its own
// unsigned compare against the query address. Depends on sat_pkg.
module sat_lanes
  import sat_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  sat_wr_t                 wr,
  input  logic                    v2f,
  input  logic [ADDR_BITS-1:0]    addr,
  input  logic [CNT_W-1:0]        count,
  output logic [MAX_SECTIONS-1:0] ge,
  output logic                    ident
);

  logic [ADDR_BITS-1:0]    vlane_r [MAX_SECTIONS];
  logic [ADDR_BITS-1:0]    rlane_r [MAX_SECTIONS];
  logic [MAX_SECTIONS-1:0] ge_r, ge_nxt;
  logic                    ident_r, ident_nxt;
  logic [ADDR_BITS-1:0]    key0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      if (adv && wr.en && (32'(wr.idx) == i)) begin
        vlane_r[i] <= wr.vstart;
        rlane_r[i] <= wr.rstart;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      ge_nxt[i] = (addr >= (v2f ? vlane_r[i] : rlane_r[i])) && (32'(count) > i);
    end
    key0      = v2f ? vlane_r[0] : rlane_r[0];
    ident_nxt = (count == '0) || (addr < key0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r    <= '0;
      ident_r <= 1'b0;
    end else if (adv) begin
      ge_r    <= ge_nxt;
      ident_r <= ident_nxt;
    end
  end

  assign ge    = ge_r;
  assign ident = ident_r;

endmodule

### hdl/sat_prio.sv
// Two-stage priority encoder: highest set lane within groups of eight,
// then highest non-empty group. Depends on sat_pkg.
module sat_prio
  import sat_pkg::*;
#(
  parameter int MAX_SECTIONS = 16,
  parameter int AW           = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic [MAX_SECTIONS-1:0] ge,
  output logic [AW-1:0]           hit
);

  localparam int NGRP  = (MAX_SECTIONS + GRP_LANES - 1) / GRP_LANES;
  localparam int PAD_W = NGRP * GRP_LANES;

  logic [PAD_W-1:0] ge_pad;
  logic [NGRP-1:0]  any_r, any_nxt;
  logic [POS_W-1:0] pos_r   [NGRP];
  logic [POS_W-1:0] pos_nxt [NGRP];
  logic [AW-1:0]    hit_r, hit_nxt;

  assign ge_pad = PAD_W'(ge);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      any_nxt[g] = 1'b0;
      pos_nxt[g] = '0;
      for (int j = 0; j < GRP_LANES; j++) begin
        if (ge_pad[g*GRP_LANES + j]) begin
          any_nxt[g] = 1'b1;
          pos_nxt[g] = POS_W'(j);
        end
      end
    end
  end

  always_comb begin
    hit_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (any_r[g]) begin
        hit_nxt = AW'(g * GRP_LANES + int'(pos_r[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= '0;
      hit_r <= '0;
    end else if (adv) begin
      any_r <= any_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < NGRP; g++) begin
        pos_r[g] <= pos_nxt[g];
      end
    end
  end

  assign hit = hit_r;

endmodule
